@@ rtl/core/bilinear_image_scaler_top_defines.svh @@
// assertion macros for the bilinear image scaler
// used by bilinear_image_scaler_top; needs clk and arst_n in scope
`ifndef BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BIS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bis assertion failed");
`define BIS_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bis assertion failed");
`else
`define BIS_ASSERT_IMPLY(label, ante, cons)
`define BIS_ASSERT_NEVER(label, cond)
`endif
`endif

@@ rtl/core/bis_pkg.sv @@
// shared types and constants of the bilinear image scaler
// no dependencies
package bis_pkg;
	localparam int IDX_W   = 16;
	localparam int PIX_W   = 24;
	localparam int COORD_W = 12;
	localparam int STEP_W  = 24;
	localparam int SIZE_W  = 9;
	localparam int POS_W   = COORD_W + STEP_W;
	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = 2;
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;
	localparam logic [7:0] CH_MAX = 8'hff;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_REQ  = 1'b1
	} act_t;

	typedef enum logic [1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_X_STEP     = 2'd2,
		CFG_Y_STEP     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		act_t             act;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] pix;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0] src_width;
		logic [SIZE_W-1:0] src_height;
	} size_cfg_t;

	typedef struct packed {
		logic reserve;
		logic wr;
	} rq_ctl_t;

	typedef struct packed {
		logic space_ok;
		logic full;
	} rq_stat_t;
endpackage

@@ rtl/core/bis_front.sv @@
// front end: takes items, forms source positions, queues commands
// depends on bis_pkg
module bis_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       action,
	input  logic [bis_pkg::IDX_W-1:0]  load_index,
	input  logic [bis_pkg::PIX_W-1:0]  pixel_in,
	input  logic [bis_pkg::COORD_W-1:0] out_col,
	input  logic [bis_pkg::COORD_W-1:0] out_row,
	input  logic [bis_pkg::STEP_W-1:0] x_step,
	input  logic [bis_pkg::STEP_W-1:0] y_step,
	input  logic                       deq,
	output logic                       head_valid,
	output bis_pkg::cmd_t              head
);
	import bis_pkg::*;

	cmd_t            entry_q [IQ_DEPTH];
	logic [IQ_AW-1:0] wptr_q, rptr_q;
	logic [IQ_AW:0]   cnt_q;
	cmd_t            cmd;
	logic            wr, rd;

	always_comb begin
		cmd.act   = act_t'(action);
		cmd.idx   = load_index;
		cmd.pix   = pixel_in;
		cmd.pos_x = POS_W'(out_col) * POS_W'(x_step);
		cmd.pos_y = POS_W'(out_row) * POS_W'(y_step);
	end

	assign full       = (cnt_q == (IQ_AW+1)'(IQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rptr_q];
	assign wr         = push && !full;
	assign rd         = deq && head_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (IQ_AW+1)'(wr) - (IQ_AW+1)'(rd);
		end
	end
endmodule

@@ rtl/core/bis_back.sv @@
// back end: clamp, address, frame store access and blend pipeline
// depends on bis_pkg; holds the two frame store copies
module bis_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bis_pkg::size_cfg_t        cfg,
	input  logic                      head_valid,
	input  bis_pkg::cmd_t             head,
	output logic                      deq,
	input  bis_pkg::rq_stat_t         rq_stat,
	output bis_pkg::rq_ctl_t          rq_ctl,
	output logic [bis_pkg::PIX_W-1:0] res_pix
);
	import bis_pkg::*;

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int SZW  = (WW > HW) ? WW : HW;
	localparam int FW   = FRAC_BITS + 1;
	localparam int WTW  = 2 * FRAC_BITS + 1;
	localparam int PRW  = WTW + 8;
	localparam int SUMW = WTW + 10;

	function automatic logic [SZW+FW-1:0] locate(input logic [POS_W-1:0] pos,
		input logic [SZW-1:0] size);
		logic [POS_W-1:0] top;
		logic [POS_W-1:0] pc;
		logic [SZW-1:0]   ip;
		logic [FW-1:0]    fr;
		top = POS_W'(size - SZW'(1)) << FRAC_BITS;
		pc  = (pos > top) ? top : pos;
		ip  = SZW'(pc >> FRAC_BITS);
		fr  = FW'(pc[FRAC_BITS-1:0]);
		if (ip > size - SZW'(2)) begin
			ip = size - SZW'(2);
			fr = FW'(1) << FRAC_BITS;
		end
		return {ip, fr};
	endfunction

	logic [PIX_W-1:0] mem0 [STORE_DEPTH];
	logic [PIX_W-1:0] mem1 [STORE_DEPTH];

	logic [SZW-1:0]   w_c, h_c;
	logic [SZW+FW-1:0] loc_x, loc_y;
	logic             req_pop;

	logic             v_s1;
	act_t             act_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [SZW-1:0]   xi_s1, yi_s1, w_s1;
	logic [FW-1:0]    fx_s1, fy_s1;

	logic             ld_s2, rq_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [PIX_W-1:0] pix_s2;
	logic [IDX_W-1:0] addr_s2 [4];
	logic [WTW-1:0]   wt_s2 [4];

	logic             rq_s3;
	logic [PIX_W-1:0] rd_s3 [4];
	logic [WTW-1:0]   wt_s3 [4];

	logic             rq_s4;
	logic [PRW-1:0]   prod_s4 [3][4];

	logic [31:0]      base;
	logic [FW-1:0]    gx, gy;

	always_comb begin
		w_c = (cfg.src_width < SIZE_W'(2)) ? SZW'(2) :
			(32'(cfg.src_width) > 32'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : SZW'(cfg.src_width);
		h_c = (cfg.src_height < SIZE_W'(2)) ? SZW'(2) :
			(32'(cfg.src_height) > 32'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : SZW'(cfg.src_height);
		loc_x = locate(head.pos_x, w_c);
		loc_y = locate(head.pos_y, h_c);
	end

	assign deq     = head_valid && (head.act == ACT_LOAD || rq_stat.space_ok);
	assign req_pop = deq && head.act == ACT_REQ;
	assign rq_ctl.reserve = req_pop;
	assign rq_ctl.wr      = rq_s4;

	// stage 1: clamped integer parts and fractions
	always_ff @(posedge clk) begin
		act_s1 <= head.act;
		idx_s1 <= head.idx;
		pix_s1 <= head.pix;
		xi_s1  <= loc_x[SZW+FW-1:FW];
		fx_s1  <= loc_x[FW-1:0];
		yi_s1  <= loc_y[SZW+FW-1:FW];
		fy_s1  <= loc_y[FW-1:0];
		w_s1   <= w_c;
	end

	// stage 2: neighbour addresses and weights
	always_comb begin
		base = 32'(yi_s1) * 32'(w_s1) + 32'(xi_s1);
		gx   = (FW'(1) << FRAC_BITS) - fx_s1;
		gy   = (FW'(1) << FRAC_BITS) - fy_s1;
	end

	always_ff @(posedge clk) begin
		idx_s2     <= idx_s1;
		pix_s2     <= pix_s1;
		addr_s2[0] <= IDX_W'(base);
		addr_s2[1] <= IDX_W'(base + 32'd1);
		addr_s2[2] <= IDX_W'(base + 32'(w_s1));
		addr_s2[3] <= IDX_W'(base + 32'(w_s1) + 32'd1);
		wt_s2[0]   <= WTW'(gx) * WTW'(gy);
		wt_s2[1]   <= WTW'(fx_s1) * WTW'(gy);
		wt_s2[2]   <= WTW'(gx) * WTW'(fy_s1);
		wt_s2[3]   <= WTW'(fx_s1) * WTW'(fy_s1);
	end

	// stage 3: frame store access
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			mem0[idx_s2] <= pix_s2;
			mem1[idx_s2] <= pix_s2;
		end
		rd_s3[0] <= mem0[addr_s2[0]];
		rd_s3[1] <= mem0[addr_s2[1]];
		rd_s3[2] <= mem1[addr_s2[2]];
		rd_s3[3] <= mem1[addr_s2[3]];
		wt_s3    <= wt_s2;
	end

	// stage 4: per channel weighted terms
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 4; k++) begin
				prod_s4[c][k] <= PRW'(rd_s3[k][8*(2-c) +: 8]) * PRW'(wt_s3[k]);
			end
		end
	end

	always_comb begin
		logic [SUMW-1:0] sum;
		logic [SUMW-1:0] val;
		res_pix = '0;
		for (int c = 0; c < 3; c++) begin
			sum = SUMW'(prod_s4[c][0]) + SUMW'(prod_s4[c][1]) +
				SUMW'(prod_s4[c][2]) + SUMW'(prod_s4[c][3]);
			val = sum >> (2 * FRAC_BITS);
			res_pix[8*(2-c) +: 8] = (val > SUMW'(CH_MAX)) ? CH_MAX : val[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ld_s2 <= 1'b0;
			rq_s2 <= 1'b0;
			rq_s3 <= 1'b0;
			rq_s4 <= 1'b0;
		end else begin
			v_s1  <= deq;
			ld_s2 <= v_s1 && act_s1 == ACT_LOAD;
			rq_s2 <= v_s1 && act_s1 == ACT_REQ;
			rq_s3 <= rq_s2;
			rq_s4 <= rq_s3;
		end
	end
endmodule

@@ rtl/core/bis_outq.sv @@
// result queue with slot reservation for results still in flight
// depends on bis_pkg
module bis_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bis_pkg::rq_ctl_t          rq_ctl,
	input  logic [bis_pkg::PIX_W-1:0] res_pix,
	output bis_pkg::rq_stat_t         rq_stat,
	output logic                      empty,
	input  logic                      pop,
	output logic [bis_pkg::PIX_W-1:0] pixel_out
);
	import bis_pkg::*;

	logic [PIX_W-1:0] entry_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wptr_q, rptr_q;
	logic [OQ_AW:0]   cnt_q, resv_q;
	logic             rd;

	assign empty     = (cnt_q == '0);
	assign pixel_out = entry_q[rptr_q];
	assign rd        = pop && !empty;
	assign rq_stat.space_ok = (resv_q < (OQ_AW+1)'(OQ_DEPTH));
	assign rq_stat.full     = (cnt_q == (OQ_AW+1)'(OQ_DEPTH));

	always_ff @(posedge clk) begin
		if (rq_ctl.wr) begin
			entry_q[wptr_q] <= res_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
			resv_q <= '0;
		end else begin
			if (rq_ctl.wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q  <= cnt_q + (OQ_AW+1)'(rq_ctl.wr) - (OQ_AW+1)'(rd);
			resv_q <= resv_q + (OQ_AW+1)'(rq_ctl.reserve) - (OQ_AW+1)'(rd);
		end
	end
endmodule

@@ rtl/core/bilinear_image_scaler_top.sv @@
// bilinear image scaler top level: config registers, front, back, result queue
// depends on bis_pkg, bis_front, bis_back, bis_outq and the defines header
//
// Usage: items enter through push/full. A load item (action 0) writes
// pixel_in into the frame store at load_index and gives no result. A request
// item (action 1) gives one interpolated pixel for out_col/out_row.
// Results leave through empty/pop, oldest first; pixel_out is valid while
// empty is low. Registers are written over cfg_valid/cfg_ready (always
// ready) at cfg_index: 0 src_width, 1 src_height, 2 x_step, 3 y_step.
// Throughput is one item per cycle while no request at the head waits for a
// result slot. A taken request reaches the result side through the command
// queue, with the multiply ahead of it and the clamp behind it, then the
// register of clamped parts, addressing, frame store read, weighting, and the
// result queue write. The frame store is two copies of 65536 x 24 bits, each
// read at two addresses per cycle, so all four neighbours come in one access.
// When the receiver stalls, the result queue (8 entries) fills and the back
// end holds requests once all slots are reserved; loads ahead of a held
// request still go through, then the 4-entry command queue raises full.
// Reset empties both queues and restores the registers; frame store content stays.
`include "bilinear_image_scaler_top_defines.svh"
module bilinear_image_scaler_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        action,
	input  logic [bis_pkg::IDX_W-1:0]   load_index,
	input  logic [bis_pkg::PIX_W-1:0]   pixel_in,
	input  logic [bis_pkg::COORD_W-1:0] out_col,
	input  logic [bis_pkg::COORD_W-1:0] out_row,
	output logic                        empty,
	input  logic                        pop,
	output logic [bis_pkg::PIX_W-1:0]   pixel_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [bis_pkg::STEP_W-1:0]  cfg_data
);
	import bis_pkg::*;

	size_cfg_t         size_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;
	logic              head_valid, deq;
	cmd_t              head;
	rq_ctl_t           rq_ctl;
	rq_stat_t          rq_stat;
	logic [PIX_W-1:0]  res_pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q.src_width  <= SIZE_W'(256);
			size_q.src_height <= SIZE_W'(256);
			x_step_q          <= STEP_W'(65536);
			y_step_q          <= STEP_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:  size_q.src_width  <= cfg_data[SIZE_W-1:0];
				CFG_SRC_HEIGHT: size_q.src_height <= cfg_data[SIZE_W-1:0];
				CFG_X_STEP:     x_step_q          <= cfg_data;
				CFG_Y_STEP:     y_step_q          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.load_index (load_index),
		.pixel_in   (pixel_in),
		.out_col    (out_col),
		.out_row    (out_row),
		.x_step     (x_step_q),
		.y_step     (y_step_q),
		.deq        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	bis_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (size_q),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.rq_stat    (rq_stat),
		.rq_ctl     (rq_ctl),
		.res_pix    (res_pix)
	);

	bis_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rq_ctl    (rq_ctl),
		.res_pix   (res_pix),
		.rq_stat   (rq_stat),
		.empty     (empty),
		.pop       (pop),
		.pixel_out (pixel_out)
	);

	`BIS_ASSERT_IMPLY(a_req_has_slot, deq && head.act == ACT_REQ, rq_stat.space_ok)
	`BIS_ASSERT_IMPLY(a_no_wr_when_full, rq_ctl.wr, !rq_stat.full || (pop && !empty))
	`BIS_ASSERT_IMPLY(a_result_from_wr, $fell(empty), $past(rq_ctl.wr))
endmodule
